FILE: sv/hqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hqd_pkg;

    // Field widths of one pixel.
    localparam int HUE_W   = 15;
    localparam int CHAN_W  = 16;
    localparam int WIDTH_W = 12;

    // Hue circle in 1/64 degree units.
    localparam logic [15:0] HUE_HALF = 16'd11520;
    localparam logic [15:0] HUE_FULL = 16'd23040;

    // Reset value of the row length register.
    localparam logic [WIDTH_W-1:0] IN_WIDTH_RST = 12'd2048;

    // Default number of output pixels per row that the row store holds.
    localparam int MAX_OUT_WIDTH_DEF = 1024;

    // Depth of the result queue in front of the master port.
    localparam int OUT_FIFO_DEPTH = 4;

    // One pixel, packed with hue in the lowest bits.
    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] lum;
        logic [CHAN_W-1:0] sat;
        logic [HUE_W-1:0]  hue;
    } t_hsla;

    localparam int PIX_W = $bits(t_hsla);

    // Mean of two hues over the shorter arc; a tie at 180 degrees takes the smaller.
    function automatic logic [HUE_W-1:0] hue_mean(input logic [HUE_W-1:0] a,
                                                  input logic [HUE_W-1:0] b);
        logic [HUE_W-1:0] diff;
        logic [HUE_W:0]   sum;
        logic [HUE_W-1:0] mean;
        logic [15:0]      alt_raw;
        logic [15:0]      alt;
        logic [HUE_W-1:0] res;
        diff    = (a > b) ? (a - b) : (b - a);
        sum     = {1'b0, a} + {1'b0, b};
        mean    = sum[HUE_W:1];
        alt_raw = {1'b0, mean} + HUE_HALF;
        alt     = (alt_raw >= HUE_FULL) ? (alt_raw - HUE_FULL) : alt_raw;
        if ({1'b0, diff} < HUE_HALF) begin
            res = mean;
        end else if ({1'b0, diff} > HUE_HALF) begin
            res = alt[HUE_W-1:0];
        end else begin
            res = ({1'b0, mean} < alt) ? mean : alt[HUE_W-1:0];
        end
        return res;
    endfunction

    // Floored mean of two unsigned channel values.
    function automatic logic [CHAN_W-1:0] chan_mean(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CHAN_W:1];
    endfunction

    // Mean of two pixels, channel by channel.
    function automatic t_hsla pair_mean(input t_hsla x, input t_hsla y);
        t_hsla r;
        r.hue   = hue_mean(x.hue, y.hue);
        r.sat   = chan_mean(x.sat, y.sat);
        r.lum   = chan_mean(x.lum, y.lum);
        r.alpha = chan_mean(x.alpha, y.alpha);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/hqd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: sv/hqd_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module hqd_out_fifo
    import hqd_pkg::*;
#(
    parameter int WIDTH = PIX_W + 1,
    parameter int DEPTH = OUT_FIFO_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic      [CNT_W-1:0] o_count
);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // Pointer wrap and occupancy.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_buf[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: sv/hsla_quarter_downscale.sv
`timescale 1ns / 1ps
`default_nettype none

// Halves an HSLA image in both directions: each 2x2 block of the raster input
// becomes one output pixel, averaged left/right first and then top/bottom, with
// hue taken over the shorter arc of the circle. The block takes one pixel per
// clock with no gaps needed; the pair averages of each top row go into a row
// store with one write and one read port, so a bottom-row pair reads its top
// partner once; the result goes through the stage 1 and stage 2 registers to
// the master port. Results wait in a four-entry queue, and the slave
// side stalls only when that queue, counting results still in flight, is full.
// Set the row length while no frame is running; an odd last column or row is
// dropped, and output rows longer than MAX_OUT_WIDTH are cut at that length.
module hsla_quarter_downscale
    import hqd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [WIDTH_W-1:0] i_cfg_wr_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // Fields from bit 0: hue_in[14:0], sat_in[30:15], lum_in[46:31], alpha_in[62:47], zero.
    input  wire logic [63:0]        s_axis_tdata,
    // Fields from bit 0: frame_start.
    input  wire logic               s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // Fields from bit 0: hue_out[14:0], sat_out[30:15], lum_out[46:31], alpha_out[62:47], zero.
    output logic [63:0]             m_axis_tdata,
    // Marks row_end.
    output logic                    m_axis_tlast
);

    localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int K_W    = WIDTH_W - 1;
    localparam int CNT_W  = $clog2(OUT_FIFO_DEPTH + 1);

    // Configuration register.
    logic [WIDTH_W-1:0] r_in_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width <= IN_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            r_in_width <= i_cfg_wr_data;
        end
    end

    // Effective width and number of stored pairs per row.
    logic [WIDTH_W-1:0] eff_width;
    logic [K_W-1:0]     pairs_w;
    int                 pairs;

    assign eff_width = (r_in_width < WIDTH_W'(2)) ? WIDTH_W'(2) : r_in_width;
    assign pairs_w   = eff_width[WIDTH_W-1:1];
    assign pairs     = (32'(pairs_w) > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : 32'(pairs_w);

    // Input beat and raster position.
    logic               in_beat;
    t_hsla              in_pix;
    logic [WIDTH_W-1:0] r_col;
    logic               r_row_odd;
    logic [WIDTH_W-1:0] cur_col;
    logic               cur_row_odd;
    logic [WIDTH_W:0]   col_inc;
    logic [WIDTH_W-1:0] n_col;
    logic               n_row_odd;
    logic [K_W-1:0]     cur_k;
    logic               pair_done;

    assign in_beat     = s_axis_tvalid && s_axis_tready;
    assign in_pix      = s_axis_tdata[PIX_W-1:0];
    assign cur_col     = s_axis_tuser ? '0 : r_col;
    assign cur_row_odd = s_axis_tuser ? 1'b0 : r_row_odd;
    assign col_inc     = {1'b0, cur_col} + 1'b1;
    assign cur_k       = cur_col[WIDTH_W-1:1];
    assign pair_done   = cur_col[0] && (32'(cur_k) < MAX_OUT_WIDTH);

    always_comb begin
        if (col_inc >= {1'b0, eff_width}) begin
            n_col     = '0;
            n_row_odd = !cur_row_odd;
        end else begin
            n_col     = col_inc[WIDTH_W-1:0];
            n_row_odd = cur_row_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row_odd <= 1'b0;
        end else if (in_beat) begin
            r_col     <= n_col;
            r_row_odd <= n_row_odd;
        end
    end

    // Left pixel of the current pair.
    t_hsla r_left;

    always_ff @(posedge i_clk) begin
        if (in_beat && !cur_col[0]) begin
            r_left <= in_pix;
        end
    end

    // Stage 1: a finished pair, waiting for its horizontal mean.
    logic              r_s1_valid;
    logic              r_s1_bottom;
    logic              r_s1_end;
    logic [ADDR_W-1:0] r_s1_addr;
    t_hsla             r_s1_left;
    t_hsla             r_s1_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_beat && pair_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && pair_done) begin
            r_s1_bottom <= cur_row_odd;
            r_s1_end    <= (32'(cur_k) + 1 == pairs);
            r_s1_addr   <= ADDR_W'(cur_k);
            r_s1_left   <= r_left;
            r_s1_right  <= in_pix;
        end
    end

    // Horizontal mean; top rows write the row store, bottom rows read it.
    t_hsla horiz;
    t_hsla top_pair;
    logic  store_wr;
    logic  store_rd;

    assign horiz    = pair_mean(r_s1_left, r_s1_right);
    assign store_wr = r_s1_valid && !r_s1_bottom;
    assign store_rd = r_s1_valid && r_s1_bottom;

    hqd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (horiz),
        .i_rd_en   (store_rd),
        .i_rd_addr (r_s1_addr),
        .o_rd_data (top_pair)
    );

    // Stage 2: bottom pair mean beside the top pair read from the store.
    logic  r_s2_valid;
    logic  r_s2_end;
    t_hsla r_s2_horiz;
    t_hsla vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= store_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_rd) begin
            r_s2_end   <= r_s1_end;
            r_s2_horiz <= horiz;
        end
    end

    assign vert = pair_mean(top_pair, r_s2_horiz);

    // Result queue; the slave side holds off while it could overflow.
    logic [PIX_W:0]   fifo_out;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W+1:0] reserved;

    hqd_out_fifo #(
        .WIDTH (PIX_W + 1),
        .DEPTH (OUT_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  ({r_s2_end, vert}),
        .i_pop   (m_axis_tready),
        .o_data  (fifo_out),
        .o_valid (m_axis_tvalid),
        .o_count (fifo_count)
    );

    assign reserved = (CNT_W + 2)'(fifo_count)
                    + (CNT_W + 2)'(r_s1_valid && r_s1_bottom)
                    + (CNT_W + 2)'(r_s2_valid);

    assign s_axis_tready = (32'(reserved) < OUT_FIFO_DEPTH);
    assign m_axis_tdata  = {1'b0, fifo_out[PIX_W-1:0]};
    assign m_axis_tlast  = fifo_out[PIX_W];

endmodule

`default_nettype wire
